### rtl/assert_macros.svh
// Assertion macros used by the sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also evaluated during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/gfts_pkg.sv
// Types, constants and the month-length table of the fix time sequencer
package gfts_pkg;

  localparam int YEAR_BASE      = 2020;
  localparam int YEAR_LAST      = 2199;
  localparam int CENTURY_COMMON = 2100;
  localparam int STAMP_W        = 33;
  localparam int CFG_W          = 8;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  typedef enum logic [1:0] {
    ST_ACC  = 2'd0,
    ST_SKIP = 2'd1,
    ST_REJ  = 2'd2
  } status_t;

  localparam logic REG_GAP   = 1'b0;
  localparam logic REG_FLUSH = 1'b1;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### rtl/gfts_fix_if.sv
// Request and result channel interfaces of the fix time sequencer
interface gfts_fix_if;
  logic        valid;
  logic        ready;
  logic [15:0] year;
  logic [7:0]  month;
  logic [7:0]  day;
  logic [7:0]  hour;
  logic [7:0]  minute;
  logic [7:0]  second;

  modport source (output valid, year, month, day, hour, minute, second, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface gfts_res_if;
  import gfts_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [STAMP_W-1:0]  epoch_seconds;
  logic                new_segment;
  logic                flush_now;

  modport source (output valid, status, epoch_seconds, new_segment, flush_now,
                  input ready);
  modport sink   (input valid, status, epoch_seconds, new_segment, flush_now,
                  output ready);
endinterface

### rtl/gnss_fix_time_sequencer.sv
// GNSS fix time sequencer: date check, epoch seconds, gap and flush flags
//
// Usage:
//   fix (sink): one UTC fix per request, taken when valid and ready are high.
//   res (source): one result per fix: status, epoch_seconds, new_segment,
//   flush_now, held in an output register until the receiver takes it.
//   APB port: gap_seconds at 0x0, flush_interval at 0x4, written at the
//   access phase; write only while no request is in flight.
// Steps: a fix that fails its field checks goes from S_CHECK straight to S_FIN.
//   Otherwise the day count is built by one shared 33-bit adder, one year or
//   one month per cycle, then the scaling to seconds is done as shift-and-add
//   steps on the same adder.
// Throughput: one request at a time; ready is high only while idle. A new
//   request is taken while an earlier result still waits in the output
//   register; the block holds at its last step until that register is free.
// Reset: synchronous, clears the held stamp, the flush count, the output
//   valid, and loads gap_seconds 5 and flush_interval 10.
module gnss_fix_time_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  gfts_fix_if.sink                      fix,
  gfts_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gfts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gfts_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gfts_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import gfts_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_YEARS, S_MONTHS, S_DAYS,
    S_H1, S_H2, S_H3, S_S1, S_S2, S_S3, S_S4, S_MS, S_CMP, S_FIN
  } state_t;

  localparam logic [7:0] LEAP_SKIP_OFS = 8'(CENTURY_COMMON - YEAR_BASE);

  state_t             state;
  logic [CFG_W-1:0]   gap_seconds;
  logic [CFG_W-1:0]   flush_interval;
  logic [STAMP_W-1:0] last_stamp;
  logic [7:0]         points_since_flush;

  logic [15:0]        yr;
  logic [7:0]         mo, dy, hr, mi, se;
  logic [7:0]         yr_cnt;
  logic [3:0]         mo_cnt;
  logic [STAMP_W-1:0] acc;
  logic [20:0]        base;
  status_t            res_kind;
  logic               res_seg;

  logic [STAMP_W-1:0] opnd;
  logic               acc_clr;
  logic [STAMP_W-1:0] sum;
  logic [7:0]         yr_ofs;
  logic               fields_ok;
  logic               yr_leap;
  logic [4:0]         mlen;
  logic [14:0]        ms_part;
  logic [STAMP_W:0]   gap_limit;
  logic [8:0]         cnt_inc;
  logic               flush_hit;
  logic               out_free;
  logic               res_blank;
  logic               res_acc_held;

  // field checks, leap year, month length and minute-second part of the held request
  always_comb begin
    yr_ofs    = 8'(yr - 16'(YEAR_BASE));
    fields_ok = (yr >= 16'(YEAR_BASE)) && (yr <= 16'(YEAR_LAST)) &&
                (mo >= 8'd1) && (mo <= 8'd12) && (dy >= 8'd1) && (dy <= 8'd31) &&
                (hr < 8'd24) && (mi < 8'd60) && (se < 8'd60);
    yr_leap   = (yr[1:0] == 2'b00) && (yr != 16'(CENTURY_COMMON));
    mlen      = month_len(mo[3:0]) + 5'((mo == 8'd2) && yr_leap);
    ms_part   = 15'({mi, 6'b0}) - 15'({mi, 2'b0}) + 15'(se) + 15'd1;
  end

  // operand select for the shared adder
  always_comb begin
    acc_clr = 1'b0;
    opnd    = '0;
    case (state)
      S_YEARS:  opnd = ((yr_cnt[1:0] == 2'b00) && (yr_cnt != LEAP_SKIP_OFS)) ?
                       STAMP_W'(366) : STAMP_W'(365);
      S_MONTHS: opnd = STAMP_W'(month_len(mo_cnt)) +
                       STAMP_W'((mo_cnt == 4'd2) && yr_leap);
      S_DAYS:   opnd = STAMP_W'(dy) - STAMP_W'(1);
      S_H1: begin
        acc_clr = 1'b1;
        opnd    = STAMP_W'({base, 4'b0});
      end
      S_H2:     opnd = STAMP_W'({base, 3'b0});
      S_H3:     opnd = STAMP_W'(hr);
      S_S1: begin
        acc_clr = 1'b1;
        opnd    = STAMP_W'({base, 11'b0});
      end
      S_S2:     opnd = STAMP_W'({base, 10'b0});
      S_S3:     opnd = STAMP_W'({base, 9'b0});
      S_S4:     opnd = STAMP_W'({base, 4'b0});
      S_MS:     opnd = STAMP_W'(ms_part);
      default:  opnd = '0;
    endcase
    sum = (acc_clr ? '0 : acc) + opnd;
  end

  always_comb begin
    gap_limit    = {1'b0, last_stamp} + (STAMP_W+1)'(gap_seconds);
    cnt_inc      = {1'b0, points_since_flush} + 9'd1;
    flush_hit    = cnt_inc >= {1'b0, flush_interval};
    out_free     = !res.valid || res.ready;
    res_blank    = (res.epoch_seconds == '0) && !res.new_segment && !res.flush_now;
    res_acc_held = res.valid && (res.status == ST_ACC) && (res.epoch_seconds == last_stamp);
  end

  assign fix.ready = (state == S_IDLE);
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? APB_DATA_W'(flush_interval) : APB_DATA_W'(gap_seconds);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      gap_seconds        <= CFG_W'(5);
      flush_interval     <= CFG_W'(10);
      last_stamp         <= '0;
      points_since_flush <= '0;
      res.valid          <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_GAP:   gap_seconds    <= pwdata[CFG_W-1:0];
          REG_FLUSH: flush_interval <= pwdata[CFG_W-1:0];
          default:   ;
        endcase
      end
      if (res.valid && res.ready && (state != S_FIN)) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (fix.valid) begin
            yr    <= fix.year;
            mo    <= fix.month;
            dy    <= fix.day;
            hr    <= fix.hour;
            mi    <= fix.minute;
            se    <= fix.second;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          acc     <= '0;
          yr_cnt  <= '0;
          mo_cnt  <= 4'd1;
          res_seg <= 1'b0;
          if (!fields_ok) begin
            res_kind <= (last_stamp != '0) ? ST_REJ : ST_ACC;
            state    <= S_FIN;
          end else if (dy > 8'(mlen)) begin
            res_kind <= ST_REJ;
            state    <= S_FIN;
          end else begin
            state <= S_YEARS;
          end
        end
        S_YEARS: begin
          if (yr_cnt == yr_ofs) begin
            state <= S_MONTHS;
          end else begin
            acc    <= sum;
            yr_cnt <= yr_cnt + 8'd1;
          end
        end
        S_MONTHS: begin
          if (mo_cnt == mo[3:0]) begin
            state <= S_DAYS;
          end else begin
            acc    <= sum;
            mo_cnt <= mo_cnt + 4'd1;
          end
        end
        S_DAYS: begin
          base  <= sum[20:0];
          state <= S_H1;
        end
        S_H1: begin
          acc   <= sum;
          state <= S_H2;
        end
        S_H2: begin
          acc   <= sum;
          state <= S_H3;
        end
        S_H3: begin
          base  <= sum[20:0];
          state <= S_S1;
        end
        S_S1: begin
          acc   <= sum;
          state <= S_S2;
        end
        S_S2: begin
          acc   <= sum;
          state <= S_S3;
        end
        S_S3: begin
          acc   <= sum;
          state <= S_S4;
        end
        S_S4: begin
          acc   <= sum;
          state <= S_MS;
        end
        S_MS: begin
          acc   <= sum;
          state <= S_CMP;
        end
        S_CMP: begin
          if ((last_stamp != '0) && (acc <= last_stamp)) begin
            res_kind <= ST_SKIP;
          end else begin
            res_kind <= ST_ACC;
            res_seg  <= (last_stamp != '0) && ({1'b0, acc} > gap_limit);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            res.valid         <= 1'b1;
            res.status        <= res_kind;
            res.epoch_seconds <= (res_kind == ST_REJ) ? '0 : acc;
            res.new_segment   <= (res_kind == ST_ACC) && res_seg;
            res.flush_now     <= (res_kind == ST_ACC) && flush_hit;
            if (res_kind == ST_ACC) begin
              last_stamp         <= acc;
              points_since_flush <= flush_hit ? '0 : cnt_inc[7:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_rej_clean, res.valid && (res.status == ST_REJ) |-> res_blank, "reject with data")
  `ASSERT_CLK(a_stamp_mono, 1'b1 |=> (last_stamp >= $past(last_stamp)), "held stamp went backward")
  `ASSERT_CLK(a_stamp_seen, !$stable(last_stamp) |-> res_acc_held, "held stamp changed unreported")
  `ASSERT_CLK(a_year_bound, (state == S_YEARS) |-> (yr_cnt <= yr_ofs), "year counter overrun")

endmodule
